>>> src/alr_pkg.sv
// Shared widths, request codes and status codes for the array list block.
`default_nettype none
package alr_pkg;

  // Fixed field widths of the request and response items
  localparam int unsigned REQ_W = 3;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned AMT_W = 16;
  localparam int unsigned ST_W  = 2;

  // Default sizing
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ROTL   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_ROTR   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd6;

  // Response status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

>>> src/alr_req_if.sv
// Request channel: valid/ready handshake with the request item.
`default_nettype none
interface alr_req_if;
  logic                              valid;
  logic                              ready;
  logic        [alr_pkg::REQ_W-1:0]  req_type;
  logic        [alr_pkg::POS_W-1:0]  position;
  logic signed [alr_pkg::VAL_W-1:0]  value_in;
  logic        [alr_pkg::AMT_W-1:0]  shift_amount;

  modport source (output valid, req_type, position, value_in, shift_amount, input ready);
  modport sink   (input valid, req_type, position, value_in, shift_amount, output ready);
endinterface
`default_nettype wire

>>> src/alr_rsp_if.sv
// Response channel: valid/ready handshake with the result item.
`default_nettype none
interface alr_rsp_if;
  logic                              valid;
  logic                              ready;
  logic        [alr_pkg::ST_W-1:0]   status;
  logic signed [alr_pkg::VAL_W-1:0]  value_out;
  logic                              last_item;

  modport source (output valid, status, value_out, last_item, input ready);
  modport sink   (input valid, status, value_out, last_item, output ready);
endinterface
`default_nettype wire

>>> src/alr_modu.sv
// Bit-serial restoring modulo unit: remainder of the rotate amount by the count.
`default_nettype none
module alr_modu #(
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [alr_pkg::AMT_W-1:0]   dividend_i,
  input  wire logic [CNT_W-1:0]            divisor_i,
  output logic                             done_o,
  output logic      [CNT_W-1:0]            rem_o
);

  localparam int unsigned ITER_W = $clog2(alr_pkg::AMT_W + 1);

  logic                        run_q, run_d;
  logic [ITER_W-1:0]           iter_q, iter_d;
  logic [alr_pkg::AMT_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]            dvs_q, dvs_d;
  logic [CNT_W:0]              rem_q, rem_d;
  logic [CNT_W:0]              trial;

  // One quotient bit per cycle
  always_comb begin
    run_d  = run_q;
    iter_d = iter_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q[CNT_W-1:0], dvd_q[alr_pkg::AMT_W-1]};
    if (start_i) begin
      run_d  = 1'b1;
      iter_d = ITER_W'(alr_pkg::AMT_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (run_q) begin
      if (iter_q == '0) begin
        run_d = 1'b0;
      end else begin
        rem_d  = (trial >= {1'b0, dvs_q}) ? (trial - {1'b0, dvs_q}) : trial;
        dvd_d  = {dvd_q[alr_pkg::AMT_W-2:0], 1'b0};
        iter_d = iter_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      iter_q <= '0;
    end else begin
      run_q  <= run_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = run_q && (iter_q == '0);
  assign rem_o  = rem_q[CNT_W-1:0];

  ap_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_q < {1'b0, dvs_q}))
    else $error("modulo remainder not below divisor");

endmodule
`default_nettype wire

>>> src/array_list_with_rotate_unit.sv
// Steps: append and update write during decode; read issues one memory read; remove reads and
//   writes each later entry; rotate runs the modulo unit, then one read and one write per entry;
//   dump reads each entry in turn; each result also waits for the response register to drain.
// Throughput: one request at a time; the single list memory port pair sets the per-entry cost.
// Reset: list empty, halt cleared, response register empty; list memory contents undefined,
//   no clearing pass, usable the cycle after reset.
`default_nettype none
module array_list_with_rotate_unit #(
  parameter int unsigned CAPACITY   = alr_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = alr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  alr_req_if.sink   req_i,
  alr_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned MEM_AW = IDX_W + 1;
  localparam int unsigned MEM_D  = 2 ** MEM_AW;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_DUMP_RD  = 4'd2;
  localparam logic [3:0] S_DUMP_OUT = 4'd3;
  localparam logic [3:0] S_READ_OUT = 4'd4;
  localparam logic [3:0] S_STAT_OUT = 4'd5;
  localparam logic [3:0] S_RM_RD    = 4'd6;
  localparam logic [3:0] S_RM_WR    = 4'd7;
  localparam logic [3:0] S_MOD      = 4'd8;
  localparam logic [3:0] S_ROT_RD   = 4'd9;
  localparam logic [3:0] S_ROT_WR   = 4'd10;

  logic [3:0]                       state_q, state_d;
  logic [CNT_W-1:0]                 count_q, count_d;
  logic                             halted_q, halted_d;
  logic                             bank_q, bank_d;
  logic [CNT_W-1:0]                 idx_q, idx_d;
  logic [CNT_W-1:0]                 src_q, src_d;
  logic [alr_pkg::ST_W-1:0]         stat_q, stat_d;

  // Latched request
  logic [alr_pkg::REQ_W-1:0]        req_q;
  logic [alr_pkg::POS_W-1:0]        pos_q;
  logic signed [alr_pkg::VAL_W-1:0] val_q;
  logic [alr_pkg::AMT_W-1:0]        amt_q;

  // Response register
  logic                             out_vld_q, out_vld_d;
  logic [alr_pkg::ST_W-1:0]         out_st_q, out_st_d;
  logic signed [alr_pkg::VAL_W-1:0] out_val_q, out_val_d;
  logic                             out_last_q, out_last_d;
  logic                             slot_free;

  // List memory, two banks so a rotation copies into the idle bank
  logic [DATA_WIDTH-1:0]            mem [MEM_D];
  logic [MEM_AW-1:0]                raddr_q, raddr_d;
  logic [MEM_AW-1:0]                waddr;
  logic [DATA_WIDTH-1:0]            wdata;
  logic                             we;
  logic [DATA_WIDTH-1:0]            rdata_q;

  logic                             mod_start;
  logic                             mod_done;
  logic [CNT_W-1:0]                 mod_rem;

  logic                             accept;
  logic                             pos_bad;
  logic                             last_src;
  logic [CNT_W:0]                   idx_inc;

  alr_modu #(
    .CNT_W (CNT_W)
  ) u_modu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (amt_q),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_vld_q || rsp_o.ready;
  assign pos_bad   = (8'(pos_q) >= 8'(count_q));
  assign idx_inc   = {1'b0, idx_q} + 1'b1;
  assign last_src  = ({1'b0, src_q} + 1'b1) == {1'b0, count_q};

  // Sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    halted_d   = halted_q;
    bank_d     = bank_q;
    idx_d      = idx_q;
    src_d      = src_q;
    stat_d     = stat_q;
    raddr_d    = raddr_q;
    we         = 1'b0;
    waddr      = {bank_q, idx_q[IDX_W-1:0]};
    wdata      = rdata_q;
    mod_start  = 1'b0;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_st_d   = out_st_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_IDLE;
        if (req_q == alr_pkg::REQ_DUMP) begin
          if (count_q != '0) begin
            idx_d   = '0;
            state_d = S_DUMP_RD;
          end
        end else if (!halted_q) begin
          unique case (req_q)
            alr_pkg::REQ_APPEND: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                stat_d  = alr_pkg::ST_FULL;
                state_d = S_STAT_OUT;
              end else begin
                we      = 1'b1;
                waddr   = {bank_q, count_q[IDX_W-1:0]};
                wdata   = DATA_WIDTH'(val_q);
                count_d = count_q + 1'b1;
              end
            end
            alr_pkg::REQ_REMOVE, alr_pkg::REQ_READ, alr_pkg::REQ_UPDATE: begin
              if (pos_bad) begin
                halted_d = 1'b1;
                stat_d   = alr_pkg::ST_INDEX;
                state_d  = S_STAT_OUT;
              end else if (req_q == alr_pkg::REQ_REMOVE) begin
                idx_d   = CNT_W'(pos_q);
                state_d = S_RM_RD;
              end else if (req_q == alr_pkg::REQ_READ) begin
                raddr_d = {bank_q, pos_q[IDX_W-1:0]};
                state_d = S_READ_OUT;
              end else begin
                we    = 1'b1;
                waddr = {bank_q, pos_q[IDX_W-1:0]};
                wdata = DATA_WIDTH'(val_q);
              end
            end
            alr_pkg::REQ_ROTL, alr_pkg::REQ_ROTR: begin
              if (count_q != '0) begin
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Dump: one read, then one result per entry
      S_DUMP_RD: begin
        raddr_d = {bank_q, idx_q[IDX_W-1:0]};
        src_d   = idx_q;
        state_d = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_st_d   = alr_pkg::ST_OK;
          out_val_d  = alr_pkg::VAL_W'($signed(rdata_q));
          out_last_d = last_src;
          if (last_src) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DUMP_RD;
          end
        end
      end

      S_READ_OUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_st_d   = alr_pkg::ST_OK;
          out_val_d  = alr_pkg::VAL_W'($signed(rdata_q));
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_STAT_OUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_st_d   = stat_q;
          out_val_d  = '0;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Remove: shift later entries down one place
      S_RM_RD: begin
        if (idx_inc < {1'b0, count_q}) begin
          raddr_d = {bank_q, idx_inc[IDX_W-1:0]};
          state_d = S_RM_WR;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_IDLE;
        end
      end

      S_RM_WR: begin
        we      = 1'b1;
        waddr   = {bank_q, idx_q[IDX_W-1:0]};
        wdata   = rdata_q;
        idx_d   = idx_q + 1'b1;
        state_d = S_RM_RD;
      end

      // Rotate: start source at amount mod count, right turns become left by count - k
      S_MOD: begin
        if (mod_done) begin
          if (req_q == alr_pkg::REQ_ROTR && mod_rem != '0) begin
            src_d = count_q - mod_rem;
          end else begin
            src_d = mod_rem;
          end
          idx_d   = '0;
          state_d = S_ROT_RD;
        end
      end

      S_ROT_RD: begin
        raddr_d = {bank_q, src_q[IDX_W-1:0]};
        state_d = S_ROT_WR;
      end

      S_ROT_WR: begin
        we      = 1'b1;
        waddr   = {!bank_q, idx_q[IDX_W-1:0]};
        wdata   = rdata_q;
        src_d   = last_src ? '0 : (src_q + 1'b1);
        idx_d   = idx_q + 1'b1;
        if (idx_inc == {1'b0, count_q}) begin
          bank_d  = !bank_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_ROT_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      halted_q  <= 1'b0;
      bank_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      halted_q  <= halted_d;
      bank_q    <= bank_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    src_q      <= src_d;
    stat_q     <= stat_d;
    raddr_q    <= raddr_d;
    out_st_q   <= out_st_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    if (accept) begin
      req_q <= req_i.req_type;
      pos_q <= req_i.position;
      val_q <= req_i.value_in;
      amt_q <= req_i.shift_amount;
    end
  end

  // List memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr_d];
  end

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.status    = out_st_q;
  assign rsp_o.value_out = out_val_q;
  assign rsp_o.last_item = out_last_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  ap_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared");

  ap_mod_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("modulo result outside rotate setup");

  ap_rot_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT_WR) |-> (idx_q < count_q && src_q < count_q))
    else $error("rotate index beyond count");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the array list unit: shadow list predictor, random handshakes, per-item checks.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CAP          = alr_pkg::CAPACITY_DEF;
  localparam int unsigned DW           = alr_pkg::DATA_WIDTH_DEF;
  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned SEG_ITEMS    = 140;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam longint      TIMEOUT_NS   = 16_000_000;

  // Request code with no function; the block must ignore it
  localparam logic [alr_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic        [alr_pkg::REQ_W-1:0] req_type;
    logic        [alr_pkg::POS_W-1:0] position;
    logic signed [alr_pkg::VAL_W-1:0] value_in;
    logic        [alr_pkg::AMT_W-1:0] shift_amount;
  } list_req_t;

  typedef struct {
    logic        [alr_pkg::ST_W-1:0]  status;
    logic signed [alr_pkg::VAL_W-1:0] value_out;
    logic                             last_item;
  } list_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  alr_req_if req_if ();
  alr_rsp_if rsp_if ();

  array_list_with_rotate_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stimulus backlog and the results the shadow list says are owed
  list_req_t req_backlog_q[$];
  list_rsp_t list_rsp_q[$];

  int unsigned n_req_drv  = 0;
  int unsigned n_req_acc  = 0;
  int unsigned n_mismatch = 0;
  int unsigned req_idle_pct = 36;
  int unsigned rsp_idle_pct = 83;

  // Shadow copy of the list
  logic [DW-1:0] shadow_words [CAP];
  int unsigned   shadow_cnt    = 0;
  bit            shadow_halted = 1'b0;

  // Element count as seen by the stimulus generator (no halt before the tail)
  int unsigned gen_cnt     = 0;
  bit          gen_filling = 1'b1;

  task automatic report_mismatch(string msg);
    if (n_mismatch < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    n_mismatch++;
  endtask

  // Apply one accepted request to the shadow list and queue the results it owes
  function automatic void shadow_list_step(list_req_t r);
    logic [DW-1:0] rotated [CAP];
    int unsigned   k;
    list_rsp_t     rsp;
    if (r.req_type == alr_pkg::REQ_DUMP) begin
      for (int unsigned i = 0; i < shadow_cnt; i++) begin
        rsp.status    = alr_pkg::ST_OK;
        rsp.value_out = alr_pkg::VAL_W'($signed(shadow_words[i]));
        rsp.last_item = (i + 1 == shadow_cnt);
        list_rsp_q = {list_rsp_q, rsp};
      end
      return;
    end
    if (shadow_halted || r.req_type == REQ_UNUSED) return;

    rsp.status    = alr_pkg::ST_INDEX;
    rsp.value_out = '0;
    rsp.last_item = 1'b1;
    case (r.req_type)
      alr_pkg::REQ_APPEND: begin
        if (shadow_cnt >= CAP) begin
          rsp.status = alr_pkg::ST_FULL;
          list_rsp_q = {list_rsp_q, rsp};
        end else begin
          shadow_words[shadow_cnt] = DW'(r.value_in);
          shadow_cnt++;
        end
      end
      alr_pkg::REQ_REMOVE, alr_pkg::REQ_READ, alr_pkg::REQ_UPDATE: begin
        if (r.position >= shadow_cnt) begin
          // bad index: error item, sticky halt, list untouched
          shadow_halted = 1'b1;
          list_rsp_q = {list_rsp_q, rsp};
        end else if (r.req_type == alr_pkg::REQ_REMOVE) begin
          for (int unsigned i = r.position; i + 1 < shadow_cnt; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_cnt--;
        end else if (r.req_type == alr_pkg::REQ_READ) begin
          rsp.status    = alr_pkg::ST_OK;
          rsp.value_out = alr_pkg::VAL_W'($signed(shadow_words[r.position]));
          list_rsp_q = {list_rsp_q, rsp};
        end else begin
          shadow_words[r.position] = DW'(r.value_in);
        end
      end
      alr_pkg::REQ_ROTL, alr_pkg::REQ_ROTR: begin
        if (shadow_cnt != 0) begin
          k = r.shift_amount % shadow_cnt;
          for (int unsigned i = 0; i < shadow_cnt; i++) begin
            if (r.req_type == alr_pkg::REQ_ROTL) rotated[i] = shadow_words[(i + k) % shadow_cnt];
            else rotated[(i + k) % shadow_cnt] = shadow_words[i];
          end
          for (int unsigned i = 0; i < shadow_cnt; i++) shadow_words[i] = rotated[i];
        end
      end
      default: ;
    endcase
  endfunction

  // Known values on all block inputs from time zero
  initial begin
    req_if.valid        = 1'b0;
    req_if.req_type     = '0;
    req_if.position     = '0;
    req_if.value_in     = '0;
    req_if.shift_amount = '0;
    rsp_if.ready        = 1'b0;
  end

  // Driver: presents backlog items and toggles result ready, on the falling edge
  always @(negedge clk_i) begin
    list_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      // hold the presented item until it is taken
      if (n_req_drv == n_req_acc) begin
        if (req_backlog_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
          nxt = req_backlog_q.pop_front();
          req_if.valid        <= 1'b1;
          req_if.req_type     <= nxt.req_type;
          req_if.position     <= nxt.position;
          req_if.value_in     <= nxt.value_in;
          req_if.shift_amount <= nxt.shift_amount;
          n_req_drv           <= n_req_drv + 1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: feeds accepted requests to the shadow list, checks accepted results
  always @(posedge clk_i) begin
    list_req_t seen;
    list_rsp_t want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen.req_type     = req_if.req_type;
        seen.position     = req_if.position;
        seen.value_in     = req_if.value_in;
        seen.shift_amount = req_if.shift_amount;
        shadow_list_step(seen);
        n_req_acc++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (list_rsp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected item status=%0d value=%0d last=%0b",
                                    rsp_if.status, rsp_if.value_out, rsp_if.last_item));
        end else begin
          want = list_rsp_q.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_if.status, want.status));
          if (rsp_if.value_out !== want.value_out)
            report_mismatch($sformatf("value_out got %0d want %0d",
                                      rsp_if.value_out, want.value_out));
          if (rsp_if.last_item !== want.last_item)
            report_mismatch($sformatf("last_item got %0b want %0b",
                                      rsp_if.last_item, want.last_item));
        end
      end
    end
  end

  // Add one request to the backlog, tracking the count it leaves behind
  task automatic queue_req(logic [alr_pkg::REQ_W-1:0] op, int unsigned pos,
                           logic signed [alr_pkg::VAL_W-1:0] val, int unsigned amt);
    list_req_t r;
    r.req_type     = op;
    r.position     = alr_pkg::POS_W'(pos);
    r.value_in     = val;
    r.shift_amount = alr_pkg::AMT_W'(amt);
    if (op == alr_pkg::REQ_APPEND && gen_cnt < CAP) gen_cnt++;
    if (op == alr_pkg::REQ_REMOVE && pos < gen_cnt) gen_cnt--;
    req_backlog_q = {req_backlog_q, r};
  endtask

  // Well-formed random request; swings between filling and draining the list
  task automatic queue_random_req();
    int unsigned                      pick;
    int unsigned                      pos;
    int unsigned                      amt;
    logic        [alr_pkg::REQ_W-1:0] op;
    logic signed [alr_pkg::VAL_W-1:0] val;
    if (gen_cnt == CAP && $urandom_range(3) == 0) gen_filling = 1'b0;
    else if (gen_cnt <= 1) gen_filling = 1'b1;

    pick = $urandom_range(99);
    if (gen_filling)
      op = pick < 50 ? alr_pkg::REQ_APPEND : pick < 58 ? alr_pkg::REQ_REMOVE :
           pick < 70 ? alr_pkg::REQ_READ : pick < 78 ? alr_pkg::REQ_UPDATE :
           pick < 85 ? alr_pkg::REQ_ROTL : pick < 92 ? alr_pkg::REQ_ROTR :
           pick < 97 ? alr_pkg::REQ_DUMP : REQ_UNUSED;
    else
      op = pick < 12 ? alr_pkg::REQ_APPEND : pick < 45 ? alr_pkg::REQ_REMOVE :
           pick < 62 ? alr_pkg::REQ_READ : pick < 72 ? alr_pkg::REQ_UPDATE :
           pick < 81 ? alr_pkg::REQ_ROTL : pick < 90 ? alr_pkg::REQ_ROTR :
           pick < 97 ? alr_pkg::REQ_DUMP : REQ_UNUSED;

    // indexed requests stay in range until the tail
    if (gen_cnt == 0 && (op == alr_pkg::REQ_REMOVE || op == alr_pkg::REQ_READ ||
                         op == alr_pkg::REQ_UPDATE))
      op = alr_pkg::REQ_APPEND;
    if (op == alr_pkg::REQ_REMOVE || op == alr_pkg::REQ_READ || op == alr_pkg::REQ_UPDATE) begin
      case ($urandom_range(5))
        0:       pos = 0;
        1:       pos = gen_cnt - 1;
        default: pos = $urandom_range(gen_cnt - 1, 0);
      endcase
    end else begin
      pos = $urandom_range(2 ** alr_pkg::POS_W - 1);
    end

    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7FFF_FFFF;
        2:       val = '0;
        default: val = -1;
      endcase
    end else begin
      val = $urandom;
    end

    amt = ($urandom_range(3) == 0) ? $urandom_range(3 * CAP) :
                                     $urandom_range(2 ** alr_pkg::AMT_W - 1);
    queue_req(op, pos, val, amt);
  endtask

  // Wait until every item is taken and every owed result has come back
  task automatic wait_list_idle();
    while (req_backlog_q.size() != 0 || n_req_drv != n_req_acc || list_rsp_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list corner cases, field extremes, every request code
    queue_req(alr_pkg::REQ_DUMP,   0, 0, 0);
    queue_req(alr_pkg::REQ_ROTL,   0, 0, 5);
    queue_req(alr_pkg::REQ_ROTR,   63, -1, 16'hFFFF);
    queue_req(REQ_UNUSED,          63, -1, 16'hFFFF);
    queue_req(alr_pkg::REQ_APPEND, 0, 32'sh8000_0000, 0);
    queue_req(alr_pkg::REQ_APPEND, 0, 32'sh7FFF_FFFF, 0);
    queue_req(alr_pkg::REQ_APPEND, 0, 0, 0);
    queue_req(alr_pkg::REQ_APPEND, 0, -1, 0);
    queue_req(alr_pkg::REQ_APPEND, 0, 12345, 0);
    queue_req(alr_pkg::REQ_READ,   0, 0, 0);
    queue_req(alr_pkg::REQ_READ,   4, 0, 0);
    queue_req(alr_pkg::REQ_UPDATE, 2, 32'shDEAD_BEEF, 0);
    queue_req(alr_pkg::REQ_ROTL,   0, 0, 0);
    queue_req(alr_pkg::REQ_ROTL,   0, 0, 7);
    queue_req(alr_pkg::REQ_ROTR,   0, 0, 3);
    queue_req(alr_pkg::REQ_ROTR,   0, 0, 5);
    queue_req(alr_pkg::REQ_DUMP,   0, 0, 0);
    queue_req(alr_pkg::REQ_REMOVE, 0, 0, 0);
    queue_req(alr_pkg::REQ_REMOVE, 3, 0, 0);
    queue_req(alr_pkg::REQ_REMOVE, 1, 0, 0);
    queue_req(alr_pkg::REQ_DUMP,   0, 0, 0);
    queue_req(alr_pkg::REQ_READ,   1, 0, 0);

    // sender holds off until the block has answered everything
    wait_list_idle();

    // Random: eager sender / stalling receiver, then reversed, then full speed
    repeat (SEG_ITEMS) queue_random_req();
    while (req_backlog_q.size() != 0) @(posedge clk_i);
    req_idle_pct = 83;
    rsp_idle_pct = 36;
    repeat (SEG_ITEMS) queue_random_req();
    while (req_backlog_q.size() != 0) @(posedge clk_i);
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    repeat (SEG_ITEMS) queue_random_req();
    wait_list_idle();

    // Tail: full list, then a bad index that halts the block for good
    while (gen_cnt < CAP)
      queue_req(alr_pkg::REQ_APPEND, $urandom_range(63), $urandom, $urandom);
    queue_req(alr_pkg::REQ_APPEND, 0, 32'sh7FFF_FFFF, 0);
    queue_req(alr_pkg::REQ_APPEND, 63, -1, 16'hFFFF);
    queue_req(alr_pkg::REQ_DUMP,   0, 0, 0);
    queue_req(alr_pkg::REQ_READ,   CAP - 1, 0, 0);
    queue_req(alr_pkg::REQ_ROTR,   0, 0, 16'hFFFF);
    queue_req(alr_pkg::REQ_REMOVE, CAP - 1, 0, 0);
    queue_req(alr_pkg::REQ_READ,   CAP - 1, 0, 0);
    // halted: all of these are dropped except the dumps
    queue_req(alr_pkg::REQ_APPEND, 0, 1, 0);
    queue_req(alr_pkg::REQ_REMOVE, 0, 0, 0);
    queue_req(alr_pkg::REQ_READ,   0, 0, 0);
    queue_req(alr_pkg::REQ_UPDATE, 0, 32'sh5555_5555, 0);
    queue_req(alr_pkg::REQ_ROTL,   0, 0, 1);
    queue_req(alr_pkg::REQ_ROTR,   0, 0, 1);
    queue_req(REQ_UNUSED,          0, 0, 0);
    queue_req(alr_pkg::REQ_DUMP,   0, 0, 0);
    queue_req(alr_pkg::REQ_READ,   CAP - 1, 0, 0);
    queue_req(alr_pkg::REQ_DUMP,   0, 0, 0);

    wait_list_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
src/alr_pkg.sv
src/alr_req_if.sv
src/alr_rsp_if.sv
src/alr_modu.sv
src/array_list_with_rotate_unit.sv
sim/tb_top.sv
